// File: design/tsl_pkg.sv
// ----------------------------------------------------------------------------
// tsl_pkg
// Shared types and constants of the two-level sorted tag lookup.
// ----------------------------------------------------------------------------
package tsl_pkg;

    // field widths of the stream payloads
    localparam int SLOT_W    = 10;
    localparam int ID_W      = 16;
    localparam int START_W   = 10;
    localparam int COUNT_W   = 11;
    localparam int VALUE_W   = 32;
    localparam int IDX_W     = 10;
    localparam int ACTION_W  = 2;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 16;

    // configuration port
    localparam int CFG_W      = 5;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic CFG_IDX_COUNT = 1'b0;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WR_REG     = 2'd0,
        ACT_WR_TAG     = 2'd1,
        ACT_FIND_FIRST = 2'd2,
        ACT_FIND_EXACT = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_REG_ISSUE,
        ST_REG_CMP,
        ST_TAG_ISSUE,
        ST_TAG_CMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [START_W-1:0] start;
        logic [COUNT_W-1:0] count;
    } t_reg_entry;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic wr_reg;
        logic wr_tag;
        logic reg_init;
        logic reg_read;
        logic tag_init;
        logic tag_read;
        logic lo_up;
        logic hi_dn;
        logic hit_first;
        logic hit_exact;
        logic miss;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_action action;
        logic    range_empty;
        logic    reg_eq;
        logic    reg_lt;
        logic    cnt_zero;
        logic    tag_eq;
        logic    tag_lt;
        logic    out_busy;
    } t_status;

endpackage

// File: design/tsl_ctrl.sv
// ----------------------------------------------------------------------------
// tsl_ctrl
// Sequencer of the lookup: dispatches writes and steps both binary searches.
// ----------------------------------------------------------------------------
module tsl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  tsl_pkg::t_status i_status,
    output tsl_pkg::t_cmd    o_cmd
);

    tsl_pkg::t_state r_state;
    tsl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            tsl_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = tsl_pkg::ST_DISPATCH;
                end
            end
            tsl_pkg::ST_DISPATCH: begin
                unique case (i_status.action)
                    tsl_pkg::ACT_WR_REG: begin
                        o_cmd.wr_reg = 1'b1;
                        n_state      = tsl_pkg::ST_IDLE;
                    end
                    tsl_pkg::ACT_WR_TAG: begin
                        o_cmd.wr_tag = 1'b1;
                        n_state      = tsl_pkg::ST_IDLE;
                    end
                    tsl_pkg::ACT_FIND_FIRST, tsl_pkg::ACT_FIND_EXACT: begin
                        o_cmd.reg_init = 1'b1;
                        n_state        = tsl_pkg::ST_REG_ISSUE;
                    end
                endcase
            end
            tsl_pkg::ST_REG_ISSUE: begin
                if (i_status.range_empty) begin
                    o_cmd.miss = 1'b1;
                    n_state    = tsl_pkg::ST_DONE;
                end else begin
                    o_cmd.reg_read = 1'b1;
                    n_state        = tsl_pkg::ST_REG_CMP;
                end
            end
            tsl_pkg::ST_REG_CMP: begin
                priority if (i_status.reg_eq && i_status.cnt_zero) begin
                    o_cmd.miss = 1'b1;
                    n_state    = tsl_pkg::ST_DONE;
                end else if (i_status.reg_eq &&
                             i_status.action == tsl_pkg::ACT_FIND_FIRST) begin
                    o_cmd.hit_first = 1'b1;
                    n_state         = tsl_pkg::ST_DONE;
                end else if (i_status.reg_eq) begin
                    o_cmd.tag_init = 1'b1;
                    n_state        = tsl_pkg::ST_TAG_ISSUE;
                end else if (i_status.reg_lt) begin
                    o_cmd.lo_up = 1'b1;
                    n_state     = tsl_pkg::ST_REG_ISSUE;
                end else begin
                    o_cmd.hi_dn = 1'b1;
                    n_state     = tsl_pkg::ST_REG_ISSUE;
                end
            end
            tsl_pkg::ST_TAG_ISSUE: begin
                if (i_status.range_empty) begin
                    o_cmd.miss = 1'b1;
                    n_state    = tsl_pkg::ST_DONE;
                end else begin
                    o_cmd.tag_read = 1'b1;
                    n_state        = tsl_pkg::ST_TAG_CMP;
                end
            end
            tsl_pkg::ST_TAG_CMP: begin
                priority if (i_status.tag_eq) begin
                    o_cmd.hit_exact = 1'b1;
                    n_state         = tsl_pkg::ST_DONE;
                end else if (i_status.tag_lt) begin
                    o_cmd.lo_up = 1'b1;
                    n_state     = tsl_pkg::ST_TAG_ISSUE;
                end else begin
                    o_cmd.hi_dn = 1'b1;
                    n_state     = tsl_pkg::ST_TAG_ISSUE;
                end
            end
            tsl_pkg::ST_DONE: begin
                // hold the result until the output register frees up
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = tsl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tsl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/tsl_dp.sv
// ----------------------------------------------------------------------------
// tsl_dp
// Datapath of the lookup: item registers, both tables, search bounds,
// compares and the output register.
// ----------------------------------------------------------------------------
module tsl_dp #(
    parameter int REGISTRY_DEPTH = 16,
    parameter int TAG_DEPTH      = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tsl_pkg::t_cmd                 i_cmd,
    output tsl_pkg::t_status              o_status,
    input  tsl_pkg::t_action              i_action,
    input  logic [tsl_pkg::SLOT_W-1:0]    i_slot,
    input  logic [tsl_pkg::ID_W-1:0]      i_category_id,
    input  logic [tsl_pkg::START_W-1:0]   i_slice_start,
    input  logic [tsl_pkg::COUNT_W-1:0]   i_slice_count,
    input  logic [tsl_pkg::VALUE_W-1:0]   i_search_value,
    input  logic [tsl_pkg::CFG_W-1:0]     i_registry_count,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic                          o_found,
    output logic [tsl_pkg::IDX_W-1:0]     o_tag_index
);

    localparam int RAW = (REGISTRY_DEPTH > 1) ? $clog2(REGISTRY_DEPTH) : 1;
    localparam int TAW = $clog2(TAG_DEPTH);
    localparam int CW  = tsl_pkg::COUNT_W;

    // captured item
    tsl_pkg::t_action                r_action;
    logic [tsl_pkg::SLOT_W-1:0]      r_slot;
    logic [tsl_pkg::ID_W-1:0]        r_cat;
    logic [tsl_pkg::START_W-1:0]     r_start;
    logic [tsl_pkg::COUNT_W-1:0]     r_count;
    logic [tsl_pkg::VALUE_W-1:0]     r_value;

    // tables
    tsl_pkg::t_reg_entry             r_reg_mem [REGISTRY_DEPTH];
    logic [tsl_pkg::VALUE_W-1:0]     r_tag_mem [TAG_DEPTH];
    tsl_pkg::t_reg_entry             r_reg_rd;
    logic [tsl_pkg::VALUE_W-1:0]     r_tag_rd;
    logic                            r_tag_oob;

    // search state
    logic [CW-1:0]                   r_lo;
    logic [CW-1:0]                   r_hi;
    logic [CW-1:0]                   r_mid;
    logic [tsl_pkg::IDX_W-1:0]       r_addr;
    logic                            r_found;
    logic [tsl_pkg::IDX_W-1:0]       r_idx;

    // output register
    logic                            r_m_valid;
    logic                            r_out_found;
    logic [tsl_pkg::IDX_W-1:0]       r_out_idx;

    logic [CW-1:0]                   w_mid;
    logic [CW-1:0]                   w_hi_init;
    logic [31:0]                     w_slot_ext;
    logic [31:0]                     w_mid_ext;
    logic [31:0]                     w_tag_addr_ext;
    logic [tsl_pkg::IDX_W-1:0]       w_tag_addr;
    logic [tsl_pkg::VALUE_W-1:0]     w_tag_val;

    assign w_mid          = r_lo + ((r_hi - r_lo) >> 1);
    assign w_slot_ext     = 32'(r_slot);
    assign w_mid_ext      = 32'(w_mid);
    assign w_tag_addr     = r_reg_rd.start + w_mid[tsl_pkg::IDX_W-1:0];
    assign w_tag_addr_ext = 32'(w_tag_addr);
    assign w_hi_init      = (32'(i_registry_count) > 32'(REGISTRY_DEPTH)) ?
                            CW'(REGISTRY_DEPTH) : CW'(i_registry_count);
    // tag addresses past the table read as zero
    assign w_tag_val      = r_tag_oob ? '0 : r_tag_rd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_slot   <= i_slot;
            r_cat    <= i_category_id;
            r_start  <= i_slice_start;
            r_count  <= i_slice_count;
            r_value  <= i_search_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_reg && (w_slot_ext < 32'(REGISTRY_DEPTH))) begin
            r_reg_mem[w_slot_ext[RAW-1:0]] <= '{id: r_cat, start: r_start, count: r_count};
        end
        if (i_cmd.reg_read) begin
            r_reg_rd <= r_reg_mem[w_mid_ext[RAW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_tag && (w_slot_ext < 32'(TAG_DEPTH))) begin
            r_tag_mem[w_slot_ext[TAW-1:0]] <= r_value;
        end
        if (i_cmd.tag_read) begin
            r_tag_rd  <= r_tag_mem[w_tag_addr_ext[TAW-1:0]];
            r_tag_oob <= !(w_tag_addr_ext < 32'(TAG_DEPTH));
            r_addr    <= w_tag_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.reg_init) begin
            r_lo <= '0;
            r_hi <= w_hi_init;
        end else if (i_cmd.tag_init) begin
            r_lo <= '0;
            r_hi <= r_reg_rd.count;
        end else if (i_cmd.lo_up) begin
            r_lo <= r_mid + 1'b1;
        end else if (i_cmd.hi_dn) begin
            r_hi <= r_mid;
        end
        if (i_cmd.reg_read || i_cmd.tag_read) begin
            r_mid <= w_mid;
        end
        if (i_cmd.hit_first) begin
            r_found <= 1'b1;
            r_idx   <= r_reg_rd.start;
        end else if (i_cmd.hit_exact) begin
            r_found <= 1'b1;
            r_idx   <= r_addr;
        end else if (i_cmd.miss) begin
            r_found <= 1'b0;
            r_idx   <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_found <= r_found;
            r_out_idx   <= r_idx;
        end
    end

    always_comb begin
        o_status             = '0;
        o_status.action      = r_action;
        o_status.range_empty = !(r_lo < r_hi);
        o_status.reg_eq      = (r_reg_rd.id == r_cat);
        o_status.reg_lt      = (r_reg_rd.id < r_cat);
        o_status.cnt_zero    = (r_reg_rd.count == '0);
        o_status.tag_eq      = (w_tag_val == r_value);
        o_status.tag_lt      = (w_tag_val < r_value);
        o_status.out_busy    = r_m_valid && !i_m_tready;
    end

    assign o_m_tvalid  = r_m_valid;
    assign o_found     = r_out_found;
    assign o_tag_index = r_out_idx;

endmodule

// File: design/two_level_sorted_tag_lookup_top.sv
// ----------------------------------------------------------------------------
// two_level_sorted_tag_lookup_top
// Two-level sorted lookup: a sorted registry table names slices of a tag
// table; finds binary-search the registries and, for find-exact, then the slice.
//
//   channel   dir   handshake            payload
//   s stream  in    tvalid/tready        tuser action, tdata item fields
//   m stream  out   tvalid/tready        tuser found, tdata tag_index
//   APB       in    psel/penable/pready  registry_count at byte address 0
//
// One item at a time: a write is stored on dispatch; a find makes registry
// probes (at most 5 with 16 registries), then tag probes for a find-exact
// (at most 11), and ends early as a miss when a search runs out of range.
// A probe is one registered read of a table's single port and a compare.
// Synchronous reset clears the sequencer, the output valid and
// registry_count; table contents are kept. A stalled result stays in the
// output register while the next item is taken; the next find then waits in
// its last state until that result transfers.
// ----------------------------------------------------------------------------
module two_level_sorted_tag_lookup_top #(
    parameter int REGISTRY_DEPTH = 16,
    parameter int TAG_DEPTH      = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // s stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [tsl_pkg::S_TDATA_W-1:0]      i_s_tdata,  // slot, category_id,
                                                           // slice_start, slice_count,
                                                           // search_value, 0 pad
    input  logic [tsl_pkg::ACTION_W-1:0]       i_s_tuser,  // action
    // m stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [tsl_pkg::M_TDATA_W-1:0]      o_m_tdata,  // tag_index, 0 pad
    output logic                               o_m_tuser,  // found
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tsl_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [tsl_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tsl_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    localparam int SLOT_LO  = 0;
    localparam int ID_LO    = SLOT_LO + tsl_pkg::SLOT_W;
    localparam int START_LO = ID_LO + tsl_pkg::ID_W;
    localparam int COUNT_LO = START_LO + tsl_pkg::START_W;
    localparam int VALUE_LO = COUNT_LO + tsl_pkg::COUNT_W;

    logic [tsl_pkg::CFG_W-1:0] r_registry_count;
    tsl_pkg::t_cmd             w_cmd;
    tsl_pkg::t_status          w_status;
    logic                      w_found;
    logic [tsl_pkg::IDX_W-1:0] w_tag_index;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_registry_count <= '0;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == tsl_pkg::CFG_IDX_COUNT) begin
            r_registry_count <= pwdata[tsl_pkg::CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == tsl_pkg::CFG_IDX_COUNT) begin
            prdata = tsl_pkg::APB_DATA_W'(r_registry_count);
        end
    end

    tsl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tsl_dp #(
        .REGISTRY_DEPTH (REGISTRY_DEPTH),
        .TAG_DEPTH      (TAG_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_action         (tsl_pkg::t_action'(i_s_tuser)),
        .i_slot           (i_s_tdata[SLOT_LO  +: tsl_pkg::SLOT_W]),
        .i_category_id    (i_s_tdata[ID_LO    +: tsl_pkg::ID_W]),
        .i_slice_start    (i_s_tdata[START_LO +: tsl_pkg::START_W]),
        .i_slice_count    (i_s_tdata[COUNT_LO +: tsl_pkg::COUNT_W]),
        .i_search_value   (i_s_tdata[VALUE_LO +: tsl_pkg::VALUE_W]),
        .i_registry_count (r_registry_count),
        .i_m_tready       (i_m_tready),
        .o_m_tvalid       (o_m_tvalid),
        .o_found          (w_found),
        .o_tag_index      (w_tag_index)
    );

    assign o_m_tdata = tsl_pkg::M_TDATA_W'(w_tag_index);
    assign o_m_tuser = w_found;

endmodule

// File: design/tsl_checker.sv
// ----------------------------------------------------------------------------
// tsl_checker
// Port-level checks of the lookup, bound to the top level.
// ----------------------------------------------------------------------------
module tsl_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_tvalid,
    input logic                               o_s_tready,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [tsl_pkg::M_TDATA_W-1:0]      o_m_tdata,
    input logic                               o_m_tuser,
    input logic                               pready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // a miss reports index zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0)
        else $error("miss with nonzero tag index");

    // one item at a time: no transfer right after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input ready right after a transfer");

    // reset drops any pending result
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_pready: assert property (@(posedge i_clk)
        pready)
        else $error("pready low");

endmodule

bind two_level_sorted_tag_lookup_top tsl_checker u_tsl_checker (.*);
